// File: rtl/skf_pkg.sv
// Package for the scalar Kalman filter core: widths, register indexes,
// sequencer states and the shared fixed-point helper functions.
// Depends on nothing; every other file imports it.
package skf_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int VAR_W      = DATA_WIDTH - 1;
    localparam int GAIN_W     = FRAC_BITS + 1;
    localparam int MAG_W      = DATA_WIDTH + 1;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int RND_W      = PROD_W - FRAC_BITS;
    localparam int TERM_W     = RND_W + 1;
    localparam int SUM_W      = TERM_W + 1;
    localparam int DEN_W      = DATA_WIDTH;
    localparam int REM_W      = DEN_W + 1;
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    localparam int CNT_W      = $clog2(DIV_STEPS + 1);
    localparam int CFG_IDX_W  = 3;

    localparam logic [GAIN_W-1:0] ONE_Q = GAIN_W'(1) << FRAC_BITS;
    localparam logic [VAR_W-1:0]  VAR_MAX = {VAR_W{1'b1}};

    localparam logic [VAR_W-1:0]      RST_PROCESS_NOISE     = VAR_W'(66);
    localparam logic [VAR_W-1:0]      RST_MEASUREMENT_NOISE = VAR_W'(65536);
    localparam logic [DATA_WIDTH-1:0] RST_CONTROL_GAIN      = '0;
    localparam logic [DATA_WIDTH-1:0] RST_INITIAL_ESTIMATE  = '0;
    localparam logic [VAR_W-1:0]      RST_INITIAL_ERROR     = VAR_W'(65536);

    localparam logic FUNC_RESTART = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROCESS_NOISE     = 3'd0,
        REG_MEASUREMENT_NOISE = 3'd1,
        REG_CONTROL_GAIN      = 3'd2,
        REG_INITIAL_ESTIMATE  = 3'd3,
        REG_INITIAL_ERROR     = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMUL,
        ST_CRND,
        ST_CADD,
        ST_DSTART,
        ST_DWAIT,
        ST_EMUL,
        ST_ERND,
        ST_EADD,
        ST_VMUL,
        ST_VRND,
        ST_OUT
    } state_t;

    function automatic logic signed [DATA_WIDTH-1:0] sat_s(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] smax;
        logic signed [SUM_W-1:0] smin;
        smax = {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
        smin = ~smax;
        if (v > smax)
        begin
            return smax[DATA_WIDTH-1:0];
        end
        else if (v < smin)
        begin
            return smin[DATA_WIDTH-1:0];
        end
        return v[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [RND_W-1:0] round_shift(input logic [PROD_W-1:0] prod);
        logic [PROD_W-1:0] t;
        t = prod + (PROD_W'(1) << (FRAC_BITS - 1));
        return t[PROD_W-1:FRAC_BITS];
    endfunction

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [MAG_W-1:0] v);
        return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

endpackage

// File: rtl/skf_interfaces.sv
// Valid/ready channel interfaces for the scalar Kalman filter core:
// input items, result items and configuration writes. Depends on skf_pkg.
interface skf_item_if import skf_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic signed [DATA_WIDTH-1:0] measurement;
    logic signed [DATA_WIDTH-1:0] control_input;

    modport source(output valid, func, measurement, control_input, input ready);
    modport sink(input valid, func, measurement, control_input, output ready);
endinterface

interface skf_result_if import skf_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] estimate;
    logic        [VAR_W-1:0]      error_variance;
    logic        [GAIN_W-1:0]     gain;

    modport source(output valid, estimate, error_variance, gain, input ready);
    modport sink(input valid, estimate, error_variance, gain, output ready);
endinterface

interface skf_cfg_if import skf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [DATA_WIDTH-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/scalar_kalman_filter_core.sv
// Scalar Kalman filter core in signed Q16.16, built from a sequencer, one
// shared multiplier and an iterative divider. Depends on skf_pkg and the channel interfaces.
// A restart item goes straight to the output state; an update item first runs the control,
// divider, estimate and variance steps, the gain divider taking most of that time. The core
// takes the next item back in idle. A full result register holds the core back.
// Reset restores the configuration defaults, the estimate to 0 and the variance to 65536.
module scalar_kalman_filter_core import skf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    skf_item_if.sink     item,
    skf_result_if.source result,
    skf_cfg_if.sink      cfg
);

    state_t state_reg;
    state_t state_next;

    logic [VAR_W-1:0]             process_noise_reg;
    logic [VAR_W-1:0]             measurement_noise_reg;
    logic signed [DATA_WIDTH-1:0] control_gain_reg;
    logic signed [DATA_WIDTH-1:0] initial_estimate_reg;
    logic [VAR_W-1:0]             initial_error_reg;

    logic signed [DATA_WIDTH-1:0] estimate_reg;
    logic [VAR_W-1:0]             variance_reg;

    logic signed [DATA_WIDTH-1:0] meas_reg;
    logic signed [DATA_WIDTH-1:0] ctl_reg;
    logic signed [DATA_WIDTH-1:0] x_reg;
    logic [VAR_W-1:0]             p_reg;
    logic signed [MAG_W-1:0]      diff_reg;
    logic [GAIN_W-1:0]            k_reg;
    logic                         neg_reg;
    logic signed [TERM_W-1:0]     term_reg;

    logic                         out_valid_reg;
    logic signed [DATA_WIDTH-1:0] out_estimate_reg;
    logic [VAR_W-1:0]             out_variance_reg;
    logic [GAIN_W-1:0]            out_gain_reg;

    logic                         in_accept;
    logic                         div_start;
    logic                         div_done;
    logic [GAIN_W-1:0]            div_quot;
    logic                         out_load;
    logic [MAG_W-1:0]             mul_a;
    logic [MAG_W-1:0]             mul_b;
    logic [PROD_W-1:0]            mul_prod;
    logic [RND_W-1:0]             rnd;
    logic signed [TERM_W-1:0]     rnd_signed;
    logic [DATA_WIDTH-1:0]        p_sum;
    logic [DEN_W-1:0]             den;

    skf_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    skf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (p_reg),
        .den   (den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (item.func == FUNC_RESTART) ? ST_OUT : ST_CMUL;
                end
            end
            ST_CMUL:   state_next = ST_CRND;
            ST_CRND:   state_next = ST_CADD;
            ST_CADD:   state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DWAIT;
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_EMUL;
                end
            end
            ST_EMUL:   state_next = ST_ERND;
            ST_ERND:   state_next = ST_EADD;
            ST_EADD:   state_next = ST_VMUL;
            ST_VMUL:   state_next = ST_VRND;
            ST_VRND:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item.ready = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            ST_IDLE:   item.ready = 1'b1;
            ST_DSTART: div_start = 1'b1;
            ST_CMUL:
            begin
                mul_a = mag_of({control_gain_reg[DATA_WIDTH-1], control_gain_reg});
                mul_b = mag_of({ctl_reg[DATA_WIDTH-1], ctl_reg});
            end
            ST_EMUL:
            begin
                mul_a = mag_of(diff_reg);
                mul_b = MAG_W'(k_reg);
            end
            ST_VMUL:
            begin
                mul_a = MAG_W'(p_reg);
                mul_b = MAG_W'(ONE_Q - k_reg);
            end
            ST_OUT:    out_load = !out_valid_reg || result.ready;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        in_accept  = item.valid && item.ready;
        rnd        = round_shift(mul_prod);
        rnd_signed = neg_reg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
        p_sum      = {1'b0, variance_reg} + {1'b0, process_noise_reg};
        den        = {1'b0, p_reg} + {1'b0, measurement_noise_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_IDLE;
            process_noise_reg     <= RST_PROCESS_NOISE;
            measurement_noise_reg <= RST_MEASUREMENT_NOISE;
            control_gain_reg      <= RST_CONTROL_GAIN;
            initial_estimate_reg  <= RST_INITIAL_ESTIMATE;
            initial_error_reg     <= RST_INITIAL_ERROR;
            estimate_reg          <= RST_INITIAL_ESTIMATE;
            variance_reg          <= RST_INITIAL_ERROR;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_idx_t'(cfg.index))
                    REG_PROCESS_NOISE:     process_noise_reg     <= cfg.data[VAR_W-1:0];
                    REG_MEASUREMENT_NOISE: measurement_noise_reg <= cfg.data[VAR_W-1:0];
                    REG_CONTROL_GAIN:      control_gain_reg      <= cfg.data;
                    REG_INITIAL_ESTIMATE:  initial_estimate_reg  <= cfg.data;
                    REG_INITIAL_ERROR:     initial_error_reg     <= cfg.data[VAR_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_accept && item.func == FUNC_RESTART)
            begin
                estimate_reg <= initial_estimate_reg;
                variance_reg <= initial_error_reg;
            end
            else if (state_reg == ST_EADD)
            begin
                estimate_reg <= sat_s(SUM_W'(x_reg) + SUM_W'(term_reg));
            end
            else if (state_reg == ST_VRND)
            begin
                variance_reg <= rnd[VAR_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    meas_reg <= item.measurement;
                    ctl_reg  <= item.control_input;
                    k_reg    <= '0;
                end
            end
            ST_CMUL:   neg_reg  <= control_gain_reg[DATA_WIDTH-1] ^ ctl_reg[DATA_WIDTH-1];
            ST_CRND:   term_reg <= rnd_signed;
            ST_CADD:
            begin
                x_reg <= sat_s(SUM_W'(estimate_reg) + SUM_W'(term_reg));
                p_reg <= p_sum[DATA_WIDTH-1] ? VAR_MAX : p_sum[VAR_W-1:0];
            end
            ST_DSTART: diff_reg <= MAG_W'(meas_reg) - MAG_W'(x_reg);
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    k_reg <= div_quot;
                end
            end
            ST_EMUL:   neg_reg  <= diff_reg[MAG_W-1];
            ST_ERND:   term_reg <= rnd_signed;
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_estimate_reg <= estimate_reg;
            out_variance_reg <= variance_reg;
            out_gain_reg     <= k_reg;
        end
    end

    assign cfg.ready             = 1'b1;
    assign result.valid          = out_valid_reg;
    assign result.estimate       = out_estimate_reg;
    assign result.error_variance = out_variance_reg;
    assign result.gain           = out_gain_reg;

endmodule

// File: rtl/skf_mul.sv
// Shared unsigned multiplier with a registered product, used for the
// control term, the estimate correction and the variance scaling. Depends on skf_pkg.
module skf_mul import skf_pkg::*;
(
    input  logic              clk,
    input  logic [MAG_W-1:0]  a,
    input  logic [MAG_W-1:0]  b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

// File: rtl/skf_div.sv
// Restoring divider for the Kalman gain, one quotient bit per cycle, with
// round-to-nearest, clamping to one and a zero result for a zero divisor. Depends on skf_pkg.
module skf_div import skf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [VAR_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [GAIN_W-1:0] quot
);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [GAIN_W-1:0] q_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [GAIN_W-1:0] quot_reg;

    logic              rem_ge;
    logic [REM_W-1:0]  rem_sel;
    logic [GAIN_W:0]   q_rnd;
    logic [GAIN_W-1:0] q_final;
    logic              last_step;

    always_comb
    begin
        rem_ge    = rem_reg >= {1'b0, den_reg};
        rem_sel   = rem_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        q_rnd     = {1'b0, q_reg} + (GAIN_W + 1)'(rem_ge);
        last_step = cnt_reg == CNT_W'(DIV_STEPS);
        if (den_reg == '0)
        begin
            q_final = '0;
        end
        else if (q_rnd > {1'b0, ONE_Q})
        begin
            q_final = ONE_Q;
        end
        else
        begin
            q_final = q_rnd[GAIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= REM_W'(num);
            q_reg   <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (last_step)
            begin
                quot_reg <= q_final;
            end
            else
            begin
                rem_reg <= {rem_sel[REM_W-2:0], 1'b0};
                q_reg   <= {q_reg[GAIN_W-2:0], rem_ge};
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
